// ===== design/boundary_fill_4_connected_top_macros.svh =====
// ----------------------------------------------------------------------------
// boundary_fill_4_connected_top_macros
// Assertion macros for the boundary fill engine. They expect clk and arst_n
// to be in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_FILL_4_CONNECTED_TOP_MACROS_SVH
`define BOUNDARY_FILL_4_CONNECTED_TOP_MACROS_SVH

// ante must be followed by cons in the same cycle
`define BF4C_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond must never hold
`define BF4C_ASSERT_NEVER(lbl, cond, msg) \
	`BF4C_ASSERT_IMPLY(lbl, 1'b1, !(cond), msg)

`endif

// ===== design/bf4c_pkg.sv =====
// ----------------------------------------------------------------------------
// bf4c_pkg
// Shared types, codes and sizes of the boundary fill engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bf4c_pkg;

	localparam int FB_WIDTH_DEF    = 64;
	localparam int FB_HEIGHT_DEF   = 64;
	localparam int STACK_DEPTH_DEF = 16384;

	// command and result queue sizes
	localparam int CQ_DEPTH = 2;
	localparam int CQPW     = $clog2(CQ_DEPTH);
	localparam int CQCW     = $clog2(CQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQPW     = $clog2(OQ_DEPTH);
	localparam int OQCW     = $clog2(OQ_DEPTH + 1);

	// input command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_FILL  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_FILL_COLOR    = 2'd0;
	localparam logic [1:0] REG_BORDER_COLOR  = 2'd1;
	localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd2;
	localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd3;

	localparam logic [23:0] FILL_COLOR_RST    = 24'hFFFFFF;
	localparam logic [23:0] BORDER_COLOR_RST  = 24'hFF0000;
	localparam logic [6:0]  ACTIVE_WIDTH_RST  = 7'd64;
	localparam logic [6:0]  ACTIVE_HEIGHT_RST = 7'd64;

	// classified command
	typedef enum logic [1:0] {
		K_ZERO,
		K_WRITE,
		K_READ,
		K_FILL
	} kind_t;

	// neighbor push order
	typedef enum logic [1:0] {
		DIR_XP,
		DIR_XM,
		DIR_YP,
		DIR_YM
	} dir_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POP,
		ST_POINT,
		ST_PIXEL,
		ST_PUSH,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic [23:0] fill_color;
		logic [23:0] border_color;
		logic [6:0]  active_width;
		logic [6:0]  active_height;
	} cfg_t;

	typedef struct packed {
		logic [23:0] read_value;
		logic [12:0] painted_count;
		logic        stack_overflow;
	} result_t;

	typedef struct packed {
		logic            full;
		logic [OQCW-1:0] count;
	} oq_stat_t;

endpackage

`default_nettype wire

// ===== design/bf4c_front.sv =====
// ----------------------------------------------------------------------------
// bf4c_front
// Input side: register bank, command decode and a short command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bf4c_front import bf4c_pkg::*; #(
	parameter int FB_WIDTH  = FB_WIDTH_DEF,
	parameter int FB_HEIGHT = FB_HEIGHT_DEF,
	localparam int FAW      = $clog2(FB_WIDTH * FB_HEIGHT)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic [1:0]      command,
	input  wire logic [5:0]      x_coord,
	input  wire logic [5:0]      y_coord,
	input  wire logic [23:0]     pixel_value,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [23:0]     cfg_data,
	output cfg_t                 cfg,
	output logic                 cq_valid,
	input  wire logic            cq_take,
	output kind_t                cq_kind,
	output logic [5:0]           cq_x,
	output logic [5:0]           cq_y,
	output logic [FAW-1:0]       cq_addr,
	output logic [23:0]          cq_pixel
);

	cfg_t cfg_q;

	kind_t          kind_q  [CQ_DEPTH];
	logic [5:0]     x_q     [CQ_DEPTH];
	logic [5:0]     y_q     [CQ_DEPTH];
	logic [FAW-1:0] addr_q  [CQ_DEPTH];
	logic [23:0]    pix_q   [CQ_DEPTH];
	logic [CQPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQCW-1:0] count_q;

	logic           wr_en;
	logic           in_store;
	kind_t          kind;
	logic [FAW-1:0] addr;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fill_color    <= FILL_COLOR_RST;
			cfg_q.border_color  <= BORDER_COLOR_RST;
			cfg_q.active_width  <= ACTIVE_WIDTH_RST;
			cfg_q.active_height <= ACTIVE_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FILL_COLOR:    cfg_q.fill_color    <= cfg_data;
				REG_BORDER_COLOR:  cfg_q.border_color  <= cfg_data;
				REG_ACTIVE_WIDTH:  cfg_q.active_width  <= cfg_data[6:0];
				REG_ACTIVE_HEIGHT: cfg_q.active_height <= cfg_data[6:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_store = (int'(x_coord) < FB_WIDTH) && (int'(y_coord) < FB_HEIGHT);
	assign addr     = FAW'(y_coord) * FAW'(FB_WIDTH) + FAW'(x_coord);

	always_comb begin
		case (command)
			CMD_WRITE: kind = in_store ? K_WRITE : K_ZERO;
			CMD_READ:  kind = in_store ? K_READ : K_ZERO;
			CMD_FILL:  kind = K_FILL;
			default:   kind = K_ZERO;
		endcase
	end

	assign full     = count_q == CQCW'(CQ_DEPTH);
	assign wr_en    = push && !full;
	assign cq_valid = count_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == CQPW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cq_take) begin
				rd_ptr_q <= (rd_ptr_q == CQPW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CQCW'(wr_en) - CQCW'(cq_take);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			kind_q[wr_ptr_q] <= kind;
			x_q[wr_ptr_q]    <= x_coord;
			y_q[wr_ptr_q]    <= y_coord;
			addr_q[wr_ptr_q] <= addr;
			pix_q[wr_ptr_q]  <= pixel_value;
		end
	end

	assign cq_kind  = kind_q[rd_ptr_q];
	assign cq_x     = x_q[rd_ptr_q];
	assign cq_y     = y_q[rd_ptr_q];
	assign cq_addr  = addr_q[rd_ptr_q];
	assign cq_pixel = pix_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== design/bf4c_engine.sv =====
// ----------------------------------------------------------------------------
// bf4c_engine
// Back end: pixel store, point stack and the fill sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bf4c_engine import bf4c_pkg::*; #(
	parameter int FB_WIDTH    = FB_WIDTH_DEF,
	parameter int FB_HEIGHT   = FB_HEIGHT_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	localparam int FAW        = $clog2(FB_WIDTH * FB_HEIGHT)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cfg_t           cfg,
	input  wire logic           cq_valid,
	output logic                cq_take,
	input  wire kind_t          cq_kind,
	input  wire logic [5:0]     cq_x,
	input  wire logic [5:0]     cq_y,
	input  wire logic [FAW-1:0] cq_addr,
	input  wire logic [23:0]    cq_pixel,
	input  wire oq_stat_t       oq_stat,
	output logic                oq_push,
	output result_t             oq_data
);

	localparam int FB_SIZE = FB_WIDTH * FB_HEIGHT;
	localparam int MAXX    = (FB_WIDTH > 64) ? FB_WIDTH : 64;
	localparam int MAXY    = (FB_HEIGHT > 64) ? FB_HEIGHT : 64;
	// stack coordinates carry an offset of one
	localparam int CXW     = $clog2(MAXX + 2);
	localparam int CYW     = $clog2(MAXY + 2);
	localparam int SEW     = CXW + CYW;
	localparam int AWW     = (CXW > 7) ? CXW : 7;
	localparam int AHW     = (CYW > 7) ? CYW : 7;
	localparam int SAW     = $clog2(STACK_DEPTH);
	localparam int SPW     = $clog2(STACK_DEPTH + 1);

	eng_state_t state_q, state_nxt;

	logic [FAW-1:0] clr_addr_q;
	logic [SPW-1:0] sp_q;
	logic [12:0]    cnt_q;
	logic           ovf_q;
	dir_t           dir_q;
	logic           res_v_s1;
	kind_t          kind_s1;
	logic [CXW-1:0] xo_q;
	logic [CYW-1:0] yo_q;
	logic [FAW-1:0] addr_q;

	logic [23:0]    frame_mem_q [FB_SIZE];
	logic [23:0]    fm_rdata_q;
	logic [SEW-1:0] stack_mem_q [STACK_DEPTH];
	logic [SEW-1:0] st_rdata_q;

	logic           fm_we, fm_re;
	logic [FAW-1:0] fm_waddr, fm_raddr;
	logic [23:0]    fm_wdata;
	logic           st_we, st_re;
	logic [SAW-1:0] st_waddr, st_raddr;
	logic [SEW-1:0] st_wdata;

	logic           room;
	logic           res_set;
	kind_t          res_kind;
	logic [SPW-1:0] sp_dec;
	logic           st_full;
	logic [CXW-1:0] pxo, px;
	logic [CYW-1:0] pyo, py;
	logic           pt_skip;
	logic [FAW-1:0] pt_addr;
	logic           paint;
	logic [SEW-1:0] seed_point, nb_point;

	assign room = ({1'b0, oq_stat.count} + {{OQCW{1'b0}}, res_v_s1}) < (OQCW + 1)'(OQ_DEPTH);

	assign sp_dec   = sp_q - SPW'(1);
	assign st_raddr = sp_dec[SAW-1:0];
	assign st_full  = sp_q == SPW'(STACK_DEPTH);

	assign pxo = st_rdata_q[CXW-1:0];
	assign pyo = st_rdata_q[SEW-1:CXW];
	assign px  = pxo - CXW'(1);
	assign py  = pyo - CYW'(1);
	assign pt_skip = (pxo == '0) || (pyo == '0)
		|| !(px < CXW'(FB_WIDTH)) || !(py < CYW'(FB_HEIGHT))
		|| !(AWW'(px) < AWW'(cfg.active_width))
		|| !(AHW'(py) < AHW'(cfg.active_height));
	assign pt_addr = FAW'(py) * FAW'(FB_WIDTH) + FAW'(px);

	assign paint = (fm_rdata_q != cfg.border_color) && (fm_rdata_q != cfg.fill_color);

	assign seed_point = {CYW'(cq_y) + CYW'(1), CXW'(cq_x) + CXW'(1)};

	always_comb begin
		case (dir_q)
			DIR_XP:  nb_point = {yo_q, xo_q + CXW'(1)};
			DIR_XM:  nb_point = {yo_q, xo_q - CXW'(1)};
			DIR_YP:  nb_point = {yo_q + CYW'(1), xo_q};
			DIR_YM:  nb_point = {yo_q - CYW'(1), xo_q};
			default: nb_point = {yo_q, xo_q};
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: if (clr_addr_q == FAW'(FB_SIZE - 1)) state_nxt = ST_IDLE;
			ST_IDLE:  if (cq_valid && room && cq_kind == K_FILL) state_nxt = ST_POP;
			ST_POP:   state_nxt = (sp_q == '0) ? ST_DONE : ST_POINT;
			ST_POINT: state_nxt = pt_skip ? ST_POP : ST_PIXEL;
			ST_PIXEL: state_nxt = paint ? ST_PUSH : ST_POP;
			ST_PUSH:  if (dir_q == DIR_YM) state_nxt = ST_POP;
			ST_DONE:  if (room) state_nxt = ST_IDLE;
			default:  state_nxt = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		fm_we    = 1'b0;
		fm_waddr = addr_q;
		fm_wdata = cfg.fill_color;
		fm_re    = 1'b0;
		fm_raddr = cq_addr;
		st_we    = 1'b0;
		st_waddr = sp_q[SAW-1:0];
		st_wdata = nb_point;
		st_re    = 1'b0;
		cq_take  = 1'b0;
		res_set  = 1'b0;
		res_kind = K_FILL;
		case (state_q)
			ST_CLEAR: begin
				fm_we    = 1'b1;
				fm_waddr = clr_addr_q;
				fm_wdata = '0;
			end
			ST_IDLE: begin
				cq_take = cq_valid && room;
				if (cq_take) begin
					case (cq_kind)
						K_WRITE: begin
							fm_we    = 1'b1;
							fm_waddr = cq_addr;
							fm_wdata = cq_pixel;
						end
						K_READ: fm_re = 1'b1;
						K_FILL: begin
							st_we    = 1'b1;
							st_waddr = '0;
							st_wdata = seed_point;
						end
						default: fm_re = 1'b0;
					endcase
					res_set  = cq_kind != K_FILL;
					res_kind = cq_kind;
				end
			end
			ST_POP:   st_re = sp_q != '0;
			ST_POINT: begin
				fm_re    = !pt_skip;
				fm_raddr = pt_addr;
			end
			ST_PIXEL: fm_we = paint;
			ST_PUSH:  st_we = !st_full;
			ST_DONE:  res_set = room;
			default:  res_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			sp_q       <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			dir_q      <= DIR_XP;
			res_v_s1   <= 1'b0;
			kind_s1    <= K_ZERO;
		end else begin
			state_q  <= state_nxt;
			res_v_s1 <= res_set;
			if (res_set) kind_s1 <= res_kind;
			case (state_q)
				ST_CLEAR: clr_addr_q <= clr_addr_q + FAW'(1);
				ST_IDLE: begin
					if (cq_take && cq_kind == K_FILL) begin
						sp_q  <= SPW'(1);
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				ST_POP:   if (sp_q != '0) sp_q <= sp_dec;
				ST_PIXEL: begin
					if (paint) begin
						cnt_q <= cnt_q + 13'd1;
						dir_q <= DIR_XP;
					end
				end
				ST_PUSH: begin
					if (st_full) ovf_q <= 1'b1;
					else sp_q <= sp_q + SPW'(1);
					dir_q <= dir_t'(dir_q + 2'd1);
				end
				default: sp_q <= sp_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_POINT) begin
			xo_q   <= pxo;
			yo_q   <= pyo;
			addr_q <= pt_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (fm_we) frame_mem_q[fm_waddr] <= fm_wdata;
		if (fm_re) fm_rdata_q <= frame_mem_q[fm_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) stack_mem_q[st_waddr] <= st_wdata;
		if (st_re) st_rdata_q <= stack_mem_q[st_raddr];
	end

	assign oq_push = res_v_s1;

	always_comb begin
		oq_data = '0;
		case (kind_s1)
			K_READ: oq_data.read_value = fm_rdata_q;
			K_FILL: begin
				oq_data.painted_count  = cnt_q;
				oq_data.stack_overflow = ovf_q;
			end
			default: oq_data = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/bf4c_outq.sv =====
// ----------------------------------------------------------------------------
// bf4c_outq
// Result queue toward the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module bf4c_outq import bf4c_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_en,
	input  wire result_t wr_data,
	input  wire logic    rd_en,
	output logic         empty,
	output result_t      rd_data,
	output oq_stat_t     stat
);

	result_t         mem_q [OQ_DEPTH];
	logic [OQPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQCW-1:0] count_q;
	logic            rd_go;

	assign empty      = count_q == '0;
	assign rd_go      = rd_en && !empty;
	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = count_q == OQCW'(OQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == OQPW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_go) begin
				rd_ptr_q <= (rd_ptr_q == OQPW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OQCW'(wr_en) - OQCW'(rd_go);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

// ===== design/boundary_fill_4_connected_top.sv =====
// ----------------------------------------------------------------------------
// boundary_fill_4_connected_top
// Framebuffer engine with pixel write, pixel read and 4-connected fill.
// ----------------------------------------------------------------------------
// Input items enter through push/full, results leave through empty/pop, one
// result per item in order. Registers are written on cfg_valid (cfg_ready is
// always high); write them only while the block is idle.
// Writes and reads sustain one item per cycle while the result queue has
// room; the result of an accepted item reaches the result ports through the
// registered read of the pixel store and the result queue register.
// A fill walks the point stack one step at a time: each painted pixel takes
// a pop, a stack read, a pixel read and four pushes on the single stack write
// port; a skipped point ends after its stack read or its pixel read. A fill
// ends through the done state. No new item is taken while a fill runs.
// After reset the pixel store is cleared to black, one pixel per cycle, over
// all FB_WIDTH * FB_HEIGHT pixels (4096 by default); items queue up meanwhile
// and full rises once the command queue holds two.
// When the receiver stalls, four results wait in the result queue, then the
// engine halts and full rises after two more items.
// ----------------------------------------------------------------------------
`default_nettype none

`include "boundary_fill_4_connected_top_macros.svh"

module boundary_fill_4_connected_top import bf4c_pkg::*; #(
	parameter int FB_WIDTH    = FB_WIDTH_DEF,
	parameter int FB_HEIGHT   = FB_HEIGHT_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  command,
	input  wire logic [5:0]  x_coord,
	input  wire logic [5:0]  y_coord,
	input  wire logic [23:0] pixel_value,
	output logic             empty,
	input  wire logic        pop,
	output logic [23:0]      read_value,
	output logic [12:0]      painted_count,
	output logic             stack_overflow,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int FAW = $clog2(FB_WIDTH * FB_HEIGHT);

	cfg_t           cfg;
	logic           cq_valid, cq_take;
	kind_t          cq_kind;
	logic [5:0]     cq_x, cq_y;
	logic [FAW-1:0] cq_addr;
	logic [23:0]    cq_pixel;
	oq_stat_t       oq_stat;
	logic           oq_push;
	result_t        oq_data;
	result_t        res;

	bf4c_front #(
		.FB_WIDTH  (FB_WIDTH),
		.FB_HEIGHT (FB_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.pixel_value (pixel_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg         (cfg),
		.cq_valid    (cq_valid),
		.cq_take     (cq_take),
		.cq_kind     (cq_kind),
		.cq_x        (cq_x),
		.cq_y        (cq_y),
		.cq_addr     (cq_addr),
		.cq_pixel    (cq_pixel)
	);

	bf4c_engine #(
		.FB_WIDTH    (FB_WIDTH),
		.FB_HEIGHT   (FB_HEIGHT),
		.STACK_DEPTH (STACK_DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cq_valid (cq_valid),
		.cq_take  (cq_take),
		.cq_kind  (cq_kind),
		.cq_x     (cq_x),
		.cq_y     (cq_y),
		.cq_addr  (cq_addr),
		.cq_pixel (cq_pixel),
		.oq_stat  (oq_stat),
		.oq_push  (oq_push),
		.oq_data  (oq_data)
	);

	bf4c_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (oq_push),
		.wr_data (oq_data),
		.rd_en   (pop),
		.empty   (empty),
		.rd_data (res),
		.stat    (oq_stat)
	);

	assign read_value     = res.read_value;
	assign painted_count  = res.painted_count;
	assign stack_overflow = res.stack_overflow;

	`BF4C_ASSERT_NEVER(a_oq_overflow, oq_push && oq_stat.full, "result queue overrun")
	`BF4C_ASSERT_IMPLY(a_take_valid, cq_take, cq_valid, "command taken from empty queue")
	`BF4C_ASSERT_IMPLY(a_ovf_is_fill, !empty && stack_overflow, read_value == 24'd0, "overflow on read")
	`BF4C_ASSERT_IMPLY(a_count_is_fill, !empty && painted_count != 13'd0, read_value == 24'd0, "count on read")

endmodule

`default_nettype wire
